@@ design/pavs_pkg.sv @@
// Shared types, constants and helpers for the pattern-avoiding max-weight selector.
package pavs_pkg;

    localparam int MAX_PATTERN    = 16;
    localparam int SUM_BITS       = 40;
    localparam int WEIGHT_BITS    = 16;
    localparam int PATTERN_BITS   = 16;
    localparam int LENGTH_BITS    = 5;
    localparam int OUT_BITS       = 40;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int ROW_BITS       = $clog2(MAX_PATTERN);
    localparam int STATE_BITS     = $clog2(MAX_PATTERN + 1);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_BITS   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = CFG_INDEX_BITS'(1);

    typedef logic [STATE_BITS-1:0] state_idx_t;
    typedef logic [SUM_BITS-1:0]   metric_t;

    // One automaton row: next match length for selection bit 1 and bit 0.
    typedef struct packed {
        state_idx_t next1;
        state_idx_t next0;
    } trans_row_t;

    typedef struct packed {
        logic start;
        logic restart;
        logic last;
    } trellis_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } trellis_stat_t;

    // Pattern element k; elements beyond the register read as zero.
    function automatic logic pattern_elem(input logic [PATTERN_BITS-1:0] bits,
                                          input logic [ROW_BITS-1:0] k);
        logic e;
        e = 1'b0;
        for (int i = 0; i < PATTERN_BITS; i++)
        begin
            if (32'(k) == i)
            begin
                e = bits[i];
            end
        end
        return e;
    endfunction

endpackage

@@ design/pattern_avoiding_max_weight_selector_top.sv @@
// Top level of the pattern-avoiding maximum-weight selector.
//
// Input channel s_axis: one transaction per position; tdata carries the
// weight, tlast marks the final position of a sequence. Output channel
// m_axis: one transaction per sequence with the best total (never below
// zero, saturating), sent after the position marked by tlast.
// Configuration: cfg_write with cfg_index 0 loads the pattern bits, index 1
// the pattern length; each write rebuilds the automaton table (a read step and
// a write step per pattern element) and restarts the current sequence.
// With an effective pattern length L, a position is accepted only after the
// trellis has finished the previous one; the relax pipeline visits one
// automaton row per cycle through the metric memories.
// With L equal to zero no trellis work is done and tlast gives a zero total.
// A finished sequence's result is registered onto m_axis when it is free.
// While a result waits for m_axis_tready the block keeps accepting positions
// of the next sequence; only the completion of that next sequence waits.
// Reset returns the block to idle with an empty pattern and a zero output, and
// makes the start state the only reachable trellis state.
module pattern_avoiding_max_weight_selector_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [15:0]                           s_axis_tdata,   // [15:0] weight
    input  logic                                  s_axis_tlast,   // last_position
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [pavs_pkg::OUT_BITS-1:0]         m_axis_tdata,   // [39:0] best_total
    input  logic                                  cfg_write,
    input  logic [pavs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pavs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_HAND} top_state_t;

    top_state_t                               state_reg;
    logic [pavs_pkg::PATTERN_BITS-1:0]        pattern_bits_reg;
    logic [pavs_pkg::LENGTH_BITS-1:0]         pattern_length_reg;
    logic                                     build_start_reg;
    logic                                     last_reg, empty_reg;
    logic                                     m_valid_reg;
    logic [pavs_pkg::OUT_BITS-1:0]            m_data_reg;

    pavs_pkg::state_idx_t                     eff_len;
    logic                                     build_busy, s_accept, cfg_hit;
    logic [pavs_pkg::ROW_BITS-1:0]            tbl_row;
    pavs_pkg::trans_row_t                     tbl_data;
    pavs_pkg::trellis_ctl_t                   ctl;
    pavs_pkg::trellis_stat_t                  stat;
    pavs_pkg::metric_t                        best;

    assign eff_len = (32'(pattern_length_reg) > pavs_pkg::MAX_PATTERN)
                     ? pavs_pkg::STATE_BITS'(pavs_pkg::MAX_PATTERN)
                     : pavs_pkg::STATE_BITS'(pattern_length_reg);
    assign s_axis_tready = (state_reg == S_IDLE) && !build_busy && !build_start_reg;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_hit       = cfg_write && (cfg_index == pavs_pkg::CFG_PATTERN_BITS
                                         || cfg_index == pavs_pkg::CFG_PATTERN_LENGTH);
    assign ctl           = '{start: s_accept && (eff_len != '0),
                             restart: build_start_reg,
                             last: s_axis_tlast};
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bits_reg   <= '0;
            pattern_length_reg <= '0;
            build_start_reg    <= 1'b0;
        end
        else
        begin
            build_start_reg <= cfg_hit;
            if (cfg_write)
            begin
                case (cfg_index)
                    pavs_pkg::CFG_PATTERN_BITS:
                    begin
                        pattern_bits_reg <= cfg_data[pavs_pkg::PATTERN_BITS-1:0];
                    end
                    pavs_pkg::CFG_PATTERN_LENGTH:
                    begin
                        pattern_length_reg <= cfg_data[pavs_pkg::LENGTH_BITS-1:0];
                    end
                    default:
                    begin
                        pattern_length_reg <= pattern_length_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            last_reg    <= 1'b0;
            empty_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        last_reg <= s_axis_tlast;
                        if (eff_len != '0)
                        begin
                            state_reg <= S_RUN;
                        end
                        else if (s_axis_tlast)
                        begin
                            empty_reg <= 1'b1;
                            state_reg <= S_HAND;
                        end
                    end
                end
                S_RUN:
                begin
                    if (stat.done)
                    begin
                        empty_reg <= 1'b0;
                        state_reg <= last_reg ? S_HAND : S_IDLE;
                    end
                end
                S_HAND:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= empty_reg ? '0 : pavs_pkg::OUT_BITS'(best);
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    pavs_automaton u_automaton (
        .clk          (clk),
        .rst_n        (rst_n),
        .build_start  (build_start_reg),
        .pattern_bits (pattern_bits_reg),
        .length       (eff_len),
        .busy         (build_busy),
        .rd_row       (tbl_row),
        .rd_data      (tbl_data)
    );

    pavs_trellis u_trellis (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .weight   (s_axis_tdata),
        .length   (eff_len),
        .tbl_row  (tbl_row),
        .tbl_data (tbl_data),
        .stat     (stat),
        .best     (best)
    );

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> state_reg == S_RUN)
        else $error("trellis finished outside a running item");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !stat.busy)
        else $error("trellis busy while the block is idle");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_HAND))
        else $error("result presented without a finished sequence");

endmodule

@@ design/pavs_automaton.sv @@
// Prefix-match automaton table: memory plus a sequential KMP-style builder.
module pavs_automaton (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                build_start,
    input  logic [pavs_pkg::PATTERN_BITS-1:0]   pattern_bits,
    input  pavs_pkg::state_idx_t                length,
    output logic                                busy,
    input  logic [pavs_pkg::ROW_BITS-1:0]       rd_row,
    output pavs_pkg::trans_row_t                rd_data
);

    typedef enum logic [1:0] {B_IDLE, B_READ, B_WRITE} build_state_t;

    build_state_t                      state_reg, state_next;
    logic [pavs_pkg::ROW_BITS-1:0]     j_reg, j_next;
    logic [pavs_pkg::ROW_BITS-1:0]     x_reg, x_next;
    pavs_pkg::trans_row_t              table_mem [pavs_pkg::MAX_PATTERN];
    pavs_pkg::trans_row_t              row_reg;
    pavs_pkg::trans_row_t              new_row;
    pavs_pkg::state_idx_t              j_plus;
    pavs_pkg::state_idx_t              x_sel;
    logic [pavs_pkg::ROW_BITS-1:0]     rd_addr;
    logic                              elem;
    logic                              we;

    assign busy    = (state_reg != B_IDLE);
    assign rd_addr = busy ? x_reg : rd_row;
    assign rd_data = row_reg;
    assign we      = (state_reg == B_WRITE) && !build_start;

    always_comb
    begin
        elem   = pavs_pkg::pattern_elem(pattern_bits, j_reg);
        j_plus = pavs_pkg::STATE_BITS'(j_reg) + pavs_pkg::STATE_BITS'(1);
        // The matching element extends the match; the other falls back to the
        // row of the longest proper border.
        new_row.next0 = !elem ? j_plus : ((j_reg == '0) ? '0 : row_reg.next0);
        new_row.next1 = elem  ? j_plus : ((j_reg == '0) ? '0 : row_reg.next1);
        x_sel         = elem ? row_reg.next1 : row_reg.next0;

        state_next = state_reg;
        j_next     = j_reg;
        x_next     = x_reg;
        if (build_start)
        begin
            j_next     = '0;
            x_next     = '0;
            state_next = (length == '0) ? B_IDLE : B_READ;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    state_next = B_IDLE;
                end
                B_READ:
                begin
                    state_next = B_WRITE;
                end
                B_WRITE:
                begin
                    x_next = (j_reg == '0) ? '0 : x_sel[pavs_pkg::ROW_BITS-1:0];
                    if (j_plus >= length)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + pavs_pkg::ROW_BITS'(1);
                        state_next = B_READ;
                    end
                end
                default:
                begin
                    state_next = B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            j_reg     <= '0;
            x_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            x_reg     <= x_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            table_mem[j_reg] <= new_row;
        end
        row_reg <= table_mem[rd_addr];
    end

    // The border row being copied always lies strictly below the row being built.
    a_border_below: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_WRITE && j_reg != '0 |-> x_reg < j_reg)
        else $error("border row not below current row");

    // Exactly one selection bit extends the current match.
    a_one_extends: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ((new_row.next0 == j_plus) != (new_row.next1 == j_plus)))
        else $error("automaton row extends match on both or neither bit");

    a_build_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(build_start))
        else $error("builder started without a request");

endmodule

@@ design/pavs_trellis.sv @@
// Trellis of best path sums in ping-pong metric memories, updated by a relax pipeline.
module pavs_trellis (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pavs_pkg::trellis_ctl_t             ctl,
    input  logic [pavs_pkg::WEIGHT_BITS-1:0]   weight,
    input  pavs_pkg::state_idx_t               length,
    output logic [pavs_pkg::ROW_BITS-1:0]      tbl_row,
    input  pavs_pkg::trans_row_t               tbl_data,
    output pavs_pkg::trellis_stat_t            stat,
    output pavs_pkg::metric_t                  best
);

    typedef logic [pavs_pkg::ROW_BITS:0] mem_addr_t;

    logic                                  bank_reg, fresh_reg, run_reg, last_reg, done_reg;
    pavs_pkg::state_idx_t                  issue_reg;
    logic [pavs_pkg::WEIGHT_BITS-1:0]      weight_reg;
    logic [pavs_pkg::MAX_PATTERN-1:0]      valid_reg [2][2];
    pavs_pkg::metric_t                     f0_mem [2*pavs_pkg::MAX_PATTERN];
    pavs_pkg::metric_t                     f1_mem [2*pavs_pkg::MAX_PATTERN];
    pavs_pkg::metric_t                     f0_qa_reg, f1_qa_reg, f0_qb_reg, f1_qb_reg;
    logic                                  s1_valid_reg;
    logic [pavs_pkg::ROW_BITS-1:0]         s1_row_reg;
    logic                                  s2_valid_reg, s2_c0v_reg, s2_c1v_reg;
    pavs_pkg::metric_t                     s2_c0_reg, s2_c1_reg;
    logic [pavs_pkg::ROW_BITS-1:0]         s2_n0_reg, s2_n1_reg;
    logic                                  s3_valid_reg;
    pavs_pkg::metric_t                     s3_max_reg;
    logic                                  fwd0_en_reg, fwd1_en_reg;
    logic [pavs_pkg::ROW_BITS-1:0]         fwd0_row_reg, fwd1_row_reg;
    pavs_pkg::metric_t                     fwd0_data_reg, fwd1_data_reg;
    pavs_pkg::metric_t                     best_reg;

    logic                                  nbank, issue_go, drained;
    pavs_pkg::metric_t                     m0, m1, c0, c1, old0, old1, pmax;
    logic [pavs_pkg::SUM_BITS:0]           sum;
    logic                                  v0, v1, c0v, c1v, ov0, ov1, wr0, wr1;
    mem_addr_t                             src_addr, dst0_addr, dst1_addr;

    assign nbank    = ~bank_reg;
    assign issue_go = run_reg && (issue_reg < length);
    assign drained  = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;
    assign tbl_row  = issue_reg[pavs_pkg::ROW_BITS-1:0];
    assign src_addr = {bank_reg, issue_reg[pavs_pkg::ROW_BITS-1:0]};
    assign stat     = '{busy: run_reg, done: done_reg};
    assign best     = best_reg;

    // Stage 1: source metrics and automaton row are back; form both candidates.
    always_comb
    begin
        m0  = (fresh_reg && s1_row_reg == '0) ? '0 : f0_qa_reg;
        m1  = f1_qa_reg;
        v0  = valid_reg[bank_reg][0][s1_row_reg];
        v1  = valid_reg[bank_reg][1][s1_row_reg];
        c0  = (v0 && (!v1 || m0 >= m1)) ? m0 : m1;
        c0v = (v0 || v1) && (tbl_data.next0 < length);
        sum = {1'b0, m0} + (pavs_pkg::SUM_BITS + 1)'(weight_reg);
        c1  = sum[pavs_pkg::SUM_BITS] ? '1 : sum[pavs_pkg::SUM_BITS-1:0];
        c1v = v0 && (tbl_data.next1 < length);
        dst0_addr = {nbank, tbl_data.next0[pavs_pkg::ROW_BITS-1:0]};
        dst1_addr = {nbank, tbl_data.next1[pavs_pkg::ROW_BITS-1:0]};
    end

    // Stage 2: relax against the target, forwarding the write of the previous cycle.
    always_comb
    begin
        old0 = (fwd0_en_reg && fwd0_row_reg == s2_n0_reg) ? fwd0_data_reg : f0_qb_reg;
        old1 = (fwd1_en_reg && fwd1_row_reg == s2_n1_reg) ? fwd1_data_reg : f1_qb_reg;
        ov0  = valid_reg[nbank][0][s2_n0_reg];
        ov1  = valid_reg[nbank][1][s2_n1_reg];
        wr0  = s2_valid_reg && s2_c0v_reg && (!ov0 || s2_c0_reg > old0);
        wr1  = s2_valid_reg && s2_c1v_reg && (!ov1 || s2_c1_reg > old1);
        pmax = (s2_c0v_reg && (!s2_c1v_reg || s2_c0_reg >= s2_c1_reg)) ? s2_c0_reg : s2_c1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg     <= 1'b0;
            fresh_reg    <= 1'b1;
            run_reg      <= 1'b0;
            last_reg     <= 1'b0;
            done_reg     <= 1'b0;
            issue_reg    <= '0;
            valid_reg[0][0] <= pavs_pkg::MAX_PATTERN'(1);
            valid_reg[0][1] <= '0;
            valid_reg[1][0] <= '0;
            valid_reg[1][1] <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            fwd0_en_reg  <= 1'b0;
            fwd1_en_reg  <= 1'b0;
            best_reg     <= '0;
        end
        else if (ctl.restart)
        begin
            fresh_reg    <= 1'b1;
            run_reg      <= 1'b0;
            done_reg     <= 1'b0;
            valid_reg[bank_reg][0] <= pavs_pkg::MAX_PATTERN'(1);
            valid_reg[bank_reg][1] <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            fwd0_en_reg  <= 1'b0;
            fwd1_en_reg  <= 1'b0;
        end
        else
        begin
            done_reg     <= 1'b0;
            s1_valid_reg <= issue_go;
            s2_valid_reg <= s1_valid_reg;
            s2_c0v_reg   <= c0v;
            s2_c1v_reg   <= c1v;
            s3_valid_reg <= s2_valid_reg && (s2_c0v_reg || s2_c1v_reg);
            fwd0_en_reg  <= wr0;
            fwd1_en_reg  <= wr1;
            if (issue_go)
            begin
                issue_reg <= issue_reg + pavs_pkg::STATE_BITS'(1);
            end
            if (wr0)
            begin
                valid_reg[nbank][0][s2_n0_reg] <= 1'b1;
            end
            if (wr1)
            begin
                valid_reg[nbank][1][s2_n1_reg] <= 1'b1;
            end
            if (s3_valid_reg && s3_max_reg > best_reg)
            begin
                best_reg <= s3_max_reg;
            end
            if (ctl.start)
            begin
                run_reg   <= 1'b1;
                last_reg  <= ctl.last;
                issue_reg <= '0;
                best_reg  <= '0;
                valid_reg[nbank][0] <= '0;
                valid_reg[nbank][1] <= '0;
            end
            else if (run_reg && !issue_go && drained)
            begin
                run_reg   <= 1'b0;
                done_reg  <= 1'b1;
                bank_reg  <= nbank;
                fresh_reg <= 1'b0;
                if (last_reg)
                begin
                    // End of sequence: the bank that becomes current restarts.
                    fresh_reg <= 1'b1;
                    valid_reg[nbank][0] <= pavs_pkg::MAX_PATTERN'(1);
                    valid_reg[nbank][1] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            weight_reg <= weight;
        end
        f0_qa_reg     <= f0_mem[src_addr];
        f1_qa_reg     <= f1_mem[src_addr];
        f0_qb_reg     <= f0_mem[dst0_addr];
        f1_qb_reg     <= f1_mem[dst1_addr];
        s1_row_reg    <= issue_reg[pavs_pkg::ROW_BITS-1:0];
        s2_c0_reg     <= c0;
        s2_c1_reg     <= c1;
        s2_n0_reg     <= tbl_data.next0[pavs_pkg::ROW_BITS-1:0];
        s2_n1_reg     <= tbl_data.next1[pavs_pkg::ROW_BITS-1:0];
        s3_max_reg    <= pmax;
        fwd0_row_reg  <= s2_n0_reg;
        fwd1_row_reg  <= s2_n1_reg;
        fwd0_data_reg <= s2_c0_reg;
        fwd1_data_reg <= s2_c1_reg;
        if (wr0)
        begin
            f0_mem[{nbank, s2_n0_reg}] <= s2_c0_reg;
        end
        if (wr1)
        begin
            f1_mem[{nbank, s2_n1_reg}] <= s2_c1_reg;
        end
    end

    // A fresh trellis has only the start state reachable in the current bank.
    a_fresh_start: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg |-> valid_reg[bank_reg][0] == pavs_pkg::MAX_PATTERN'(1)
                      && valid_reg[bank_reg][1] == '0)
        else $error("fresh trellis has stray reachable states");

    a_relax_marks: assert property (@(posedge clk) disable iff (!rst_n)
        wr0 && !ctl.restart |=> valid_reg[!bank_reg][0][$past(s2_n0_reg)])
        else $error("relaxed target not marked reachable");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> $past(run_reg) && drained)
        else $error("update finished without a running item");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the pattern-avoiding maximum-weight selector.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pavs_pkg::*;

    typedef logic [WEIGHT_BITS-1:0] weight_list_t[$];

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_A = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_B = CFG_INDEX_BITS'(3);
    localparam int NUM_STATES    = 2 * MAX_PATTERN;
    localparam logic [SUM_BITS-1:0] SUM_LIMIT = {SUM_BITS{1'b1}};
    // Covers a table rebuild plus the slowest position still in flight.
    localparam int DRAIN_CYCLES  = 64;
    localparam int HOLD_CYCLES   = 500;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [15:0]                s_axis_tdata;   // [15:0] weight
    logic                       s_axis_tlast;   // last_position
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_BITS-1:0]        m_axis_tdata;   // [39:0] best_total
    logic                       cfg_write;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;

    pattern_avoiding_max_weight_selector_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predicted block state: registers, automaton and trellis.
    logic [PATTERN_BITS-1:0]    pat_bits;
    logic [LENGTH_BITS-1:0]     pat_len;
    int unsigned                next_match[NUM_STATES];
    logic [SUM_BITS-1:0]        best_sum[NUM_STATES];
    bit                         reachable[NUM_STATES];
    logic [SUM_BITS-1:0]        cand_sum[NUM_STATES];
    bit                         cand_reach[NUM_STATES];

    logic [OUT_BITS-1:0]        pending_totals[$];
    int                         failures;
    int                         send_idle_pct;
    int                         recv_idle_pct;
    logic                       hold_receiver;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned active_len();
        return (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    endfunction

    function automatic int unsigned pat_elem(input int unsigned k);
        return (k < PATTERN_BITS) ? int'(pat_bits[k]) : 0;
    endfunction

    // Longest pattern prefix that is a suffix of "prefix j, then bit c".
    function automatic void rebuild_automaton();
        int unsigned len_eff;
        int unsigned found;
        int unsigned sym;
        int unsigned pos;
        bit          ok;
        len_eff = active_len();
        for (int i = 0; i < NUM_STATES; i++)
        begin
            next_match[i] = 0;
        end
        for (int j = 0; j < len_eff; j++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                found = 0;
                for (int len = j + 1; len >= 1 && found == 0; len--)
                begin
                    ok = 1'b1;
                    for (int k = 0; k < len; k++)
                    begin
                        pos = j + 1 - len + k;
                        sym = (pos < j) ? pat_elem(pos) : c;
                        if (sym != pat_elem(k))
                        begin
                            ok = 1'b0;
                        end
                    end
                    if (ok)
                    begin
                        found = len;
                    end
                end
                next_match[2 * j + c] = found;
            end
        end
    endfunction

    function automatic void restart_trellis();
        for (int i = 0; i < NUM_STATES; i++)
        begin
            best_sum[i]  = '0;
            reachable[i] = 1'b0;
        end
        reachable[0] = 1'b1;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                            input logic [CFG_DATA_BITS-1:0] data);
        if (idx == CFG_PATTERN_BITS)
        begin
            pat_bits = data[PATTERN_BITS-1:0];
        end
        else if (idx == CFG_PATTERN_LENGTH)
        begin
            pat_len = data[LENGTH_BITS-1:0];
        end
        else
        begin
            return;
        end
        rebuild_automaton();
        restart_trellis();
    endfunction

    function automatic void relax(input int unsigned idx, input logic [SUM_BITS-1:0] val);
        if (!cand_reach[idx] || val > cand_sum[idx])
        begin
            cand_sum[idx]   = val;
            cand_reach[idx] = 1'b1;
        end
    endfunction

    // Advances the trellis by one position; returns 1 when a total is due.
    function automatic bit advance_trellis(input logic [WEIGHT_BITS-1:0] w, input bit last,
                                           output logic [OUT_BITS-1:0] total);
        int unsigned         len_eff;
        int unsigned         n0;
        int unsigned         n1;
        int unsigned         idx;
        logic [SUM_BITS-1:0] m;
        logic [SUM_BITS-1:0] best;
        len_eff = active_len();
        total = '0;
        if (len_eff == 0)
        begin
            return last;
        end
        for (int i = 0; i < NUM_STATES; i++)
        begin
            cand_sum[i]   = '0;
            cand_reach[i] = 1'b0;
        end
        for (int j = 0; j < len_eff; j++)
        begin
            for (int f = 0; f < 2; f++)
            begin
                idx = 2 * j + f;
                if (!reachable[idx])
                begin
                    continue;
                end
                m  = best_sum[idx];
                n0 = next_match[2 * j];
                if (n0 < len_eff)
                begin
                    relax(2 * n0, m);
                end
                // A position right after a selected one may not be selected.
                if (f == 0)
                begin
                    n1 = next_match[2 * j + 1];
                    if (n1 < len_eff)
                    begin
                        relax(2 * n1 + 1,
                              (m > SUM_LIMIT - SUM_BITS'(w)) ? SUM_LIMIT : m + SUM_BITS'(w));
                    end
                end
            end
        end
        for (int i = 0; i < NUM_STATES; i++)
        begin
            best_sum[i]  = cand_sum[i];
            reachable[i] = cand_reach[i];
        end
        if (!last)
        begin
            return 1'b0;
        end
        best = '0;
        for (int i = 0; i < NUM_STATES; i++)
        begin
            if (reachable[i] && best_sum[i] > best)
            begin
                best = best_sum[i];
            end
        end
        total = OUT_BITS'(best);
        restart_trellis();
        return 1'b1;
    endfunction

    task automatic note_failure(input string what, input logic [OUT_BITS-1:0] want,
                                input logic [OUT_BITS-1:0] got);
        failures++;
        if (failures <= REPORT_LIMIT)
        begin
            $display("mismatch at %0t: %s, best_total expected %0d got %0d",
                     $realtime, what, want, got);
        end
    endtask

    // Result side: random stalls, then compare every output transaction.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_totals.size() == 0)
                begin
                    note_failure("unexpected result", '0, m_axis_tdata);
                end
                else
                begin
                    if (m_axis_tdata !== pending_totals[0])
                    begin
                        note_failure("wrong total", pending_totals[0], m_axis_tdata);
                    end
                    void'(pending_totals.pop_front());
                end
            end
            m_axis_tready <= !hold_receiver && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Ends the run when no transaction of any kind happens for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || cfg_write)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_position(input logic [WEIGHT_BITS-1:0] w, input bit last);
        logic [OUT_BITS-1:0] total;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        if (advance_trellis(w, last, total))
        begin
            pending_totals.push_back(total);
        end
    endtask

    task automatic send_sequence(input weight_list_t weights, input bit finish);
        foreach (weights[i])
        begin
            send_position(weights[i], finish && (i == weights.size() - 1));
        end
    endtask

    // Registers change only with the input quiet and every result delivered.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        s_axis_tvalid <= 1'b0;
        while (pending_totals.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        apply_reg_write(idx, data);
    endtask

    task automatic program_pattern(input logic [PATTERN_BITS-1:0] bits,
                                   input logic [CFG_DATA_BITS-1:0] len_word);
        write_reg(CFG_PATTERN_BITS, bits);
        write_reg(CFG_PATTERN_LENGTH, len_word);
    endtask

    function automatic logic [WEIGHT_BITS-1:0] random_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return WEIGHT_BITS'($urandom_range(0, 15));
            default: return WEIGHT_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic program_random_pattern();
        logic [PATTERN_BITS-1:0]  bits;
        logic [CFG_DATA_BITS-1:0] len_word;
        int unsigned              len;
        case ($urandom_range(0, 9))
            0: len = 0;
            1: len = MAX_PATTERN;
            2: len = $urandom_range(MAX_PATTERN + 1, 31);
            default: len = $urandom_range(1, 5);
        endcase
        case ($urandom_range(0, 5))
            0: bits = '0;
            1: bits = '1;
            default: bits = PATTERN_BITS'($urandom_range(0, 65535));
        endcase
        // Bits above the length field carry noise that the block must drop.
        len_word = {11'($urandom_range(0, 2047)), 5'(len)};
        if ($urandom_range(0, 1) == 0)
        begin
            program_pattern(bits, len_word);
        end
        else
        begin
            write_reg(CFG_PATTERN_LENGTH, len_word);
            write_reg(CFG_PATTERN_BITS, bits);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            write_reg(($urandom_range(0, 1) == 0) ? CFG_UNUSED_A : CFG_UNUSED_B,
                      CFG_DATA_BITS'($urandom_range(0, 65535)));
        end
    endtask

    // Registers at reset give an empty pattern, so every total is zero.
    task automatic test_empty_pattern();
        send_sequence('{16'hFFFF}, 1'b1);
        send_sequence('{16'h0000, 16'h0005, 16'h0007}, 1'b1);
    endtask

    task automatic test_directed_patterns();
        // Pattern "0": every position must be selected, so two positions leave no path.
        program_pattern(16'h0000, 16'd1);
        send_sequence('{16'hFFFF}, 1'b1);
        send_sequence('{16'h1234, 16'h4321}, 1'b1);
        // Pattern "1" with noise above the length field: nothing may be selected.
        program_pattern(16'hFFFF, 16'hFFE1);
        send_sequence('{16'hFFFF, 16'hFFFF}, 1'b1);
        // Length beyond the maximum is clipped; sixteen ones never occur.
        program_pattern(16'hFFFF, 16'd31);
        send_sequence('{16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b1);
        // Pattern "101" forbids select, skip, select.
        program_pattern(16'h0005, 16'd3);
        send_sequence('{16'd10, 16'd1, 16'd10, 16'd1}, 1'b1);
        program_pattern(16'h0000, 16'd16);
        send_sequence('{16'h8000, 16'h7FFF, 16'h00FF}, 1'b1);
    endtask

    task automatic test_mid_sequence_write();
        program_pattern(16'h0005, 16'd3);
        send_sequence('{16'd40, 16'd3}, 1'b0);
        // A write to an unused index changes nothing and keeps the sequence going.
        write_reg(CFG_UNUSED_A, 16'hA5A5);
        send_sequence('{16'd9}, 1'b0);
        // A real write restarts the sequence.
        write_reg(CFG_PATTERN_LENGTH, 16'd2);
        send_sequence('{16'd7, 16'd9}, 1'b1);
    endtask

    task automatic test_random_sequences(input int target, input int send_pct,
                                         input int recv_pct);
        int sent;
        int seq_len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < target)
        begin
            if (sent == 0 || $urandom_range(0, 3) == 0)
            begin
                program_random_pattern();
            end
            // Now and then a sequence is cut short by a reconfiguration.
            if ($urandom_range(0, 9) == 0)
            begin
                seq_len = $urandom_range(1, 4);
                for (int i = 0; i < seq_len; i++)
                begin
                    send_position(random_weight(), 1'b0);
                end
                sent += seq_len;
                program_random_pattern();
            end
            seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                                   : $urandom_range(1, 8);
            for (int i = 0; i < seq_len; i++)
            begin
                send_position(random_weight(), i == seq_len - 1);
            end
            sent += seq_len;
        end
    endtask

    // The receiver stops long enough for the block to fill and stall its input.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_pattern(16'h0005, 16'd3);
        hold_receiver <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_receiver <= 1'b0;
            end
        join_none
        for (int s = 0; s < 4; s++)
        begin
            for (int i = 0; i < 5; i++)
            begin
                send_position(random_weight(), i == 4);
            end
        end
    endtask

    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        hold_receiver <= 1'b0;
        failures      = 0;
        send_idle_pct = 31;
        recv_idle_pct = 67;
        pat_bits      = '0;
        pat_len       = '0;
        rebuild_automaton();
        restart_trellis();
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pattern();
        test_directed_patterns();
        test_mid_sequence_write();
        test_random_sequences(125, 31, 67);
        test_random_sequences(125, 67, 31);
        test_random_sequences(125, 0, 0);
        test_output_backpressure();

        s_axis_tvalid <= 1'b0;
        while (pending_totals.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_totals.size() != 0)
        begin
            failures++;
        end
        if (failures == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
